@@ hw/rtl/fsr_pkg.sv @@
package fsr_pkg;

	// Command codes on the input channel
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_FETCH  = 2'd1;
	localparam logic [1:0] CMD_REWIND = 2'd2;

	// Fixed field widths
	localparam int SYM_W  = 8;
	localparam int FREQ_W = 16;

	// Number of distinct symbol codes the symbol field can carry
	localparam int SYM_RANGE = 256;

	// Control broadcast to every cell of the chain
	typedef struct packed {
		logic clr;  // drop every stored and readout entry
		logic upd;  // apply the remove and insert of a load
		logic rem;  // the loaded symbol is present and must be taken out
		logic ins;  // the loaded count is nonzero and must be placed
		logic rew;  // copy the store into the readout chain
		logic adv;  // shift the readout chain one place towards the head
	} cell_ctrl_t;

endpackage

@@ hw/rtl/fsr_cell.sv @@
module fsr_cell #(
	parameter int KW = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fsr_pkg::cell_ctrl_t ctrl,
	input  logic [KW-1:0]       new_key,
	input  logic [KW-1:0]       old_key,
	input  logic                prev_cv,
	input  logic [KW-1:0]       prev_ck,
	input  logic                prev_b,
	input  logic                next_v,
	input  logic [KW-1:0]       next_k,
	input  logic                next_rv,
	input  logic [KW-1:0]       next_rk,
	output logic                v,
	output logic [KW-1:0]       k,
	output logic                cv,
	output logic [KW-1:0]       ck,
	output logic                b,
	output logic                rv,
	output logic [KW-1:0]       rk
);

	logic          v_q;
	logic [KW-1:0] k_q;
	logic          rv_q;
	logic [KW-1:0] rk_q;
	logic          a;
	logic          nv;
	logic [KW-1:0] nk;

	// Close the gap left by the removed entry: take the neighbour behind
	always_comb begin
		a  = ctrl.rem && (!v_q || (k_q <= old_key));
		cv = a ? next_v : v_q;
		ck = a ? next_k : k_q;
		b  = !cv || (ck < new_key);
	end

	// Open a slot at the first place whose key is not above the new one
	always_comb begin
		nv = cv;
		nk = ck;
		if (ctrl.ins) begin
			if (b && !prev_b) begin
				nv = 1'b1;
				nk = new_key;
			end else if (b) begin
				nv = prev_cv;
				nk = prev_ck;
			end
		end
	end

	// Hold the stored entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ctrl.clr) begin
			v_q <= 1'b0;
		end else if (ctrl.upd) begin
			v_q <= nv;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.upd) begin
			k_q <= nk;
		end
	end

	// Hold the readout copy: reload after a load or rewind, shift on fetch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (ctrl.clr) begin
			rv_q <= 1'b0;
		end else if (ctrl.upd) begin
			rv_q <= nv;
		end else if (ctrl.rew) begin
			rv_q <= v_q;
		end else if (ctrl.adv) begin
			rv_q <= next_rv;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.upd) begin
			rk_q <= nk;
		end else if (ctrl.rew) begin
			rk_q <= k_q;
		end else if (ctrl.adv) begin
			rk_q <= next_rk;
		end
	end

	assign v  = v_q;
	assign k  = k_q;
	assign rv = rv_q;
	assign rk = rk_q;

endmodule

@@ hw/rtl/fsr_side.sv @@
module fsr_side #(
	parameter int NS = 256,
	parameter int FW = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic                  clr,
	input  logic [$clog2(NS)-1:0] rd_idx,
	input  logic                  wr_en,
	input  logic [$clog2(NS)-1:0] wr_idx,
	input  logic [FW-1:0]         wr_freq,
	output logic                  present,
	output logic [FW-1:0]         old_freq
);

	logic [NS-1:0] vld_q;
	logic [FW-1:0] mem [NS];
	logic          present_q;
	logic [FW-1:0] old_freq_q;

	// Track which symbols are held in the current set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_idx] <= (wr_freq != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
		end else if (rd_en) begin
			present_q <= vld_q[rd_idx] && !clr;
		end
	end

	// Count of each symbol, read in the cycle before the chain update
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_freq;
		end
		if (rd_en) begin
			old_freq_q <= mem[rd_idx];
		end
	end

	assign present  = present_q;
	assign old_freq = old_freq_q;

endmodule

@@ hw/rtl/frequency_sorted_symbol_readout.sv @@
// Sorted symbol count store with in-order readout.
// Input channel (in_valid/in_ready) carries command, first, symbol, frequency.
// A load writes one symbol's count (first clears the set); zero counts are
// dropped and a reloaded symbol takes its new place. A fetch returns the next
// entry, highest count first, higher symbol first on equal counts; past the
// end it returns done_res with zero fields. A rewind restarts the readout.
// Output channel (out_valid/out_ready) carries one result per fetch.
// A fetch result appears on the output register the cycle after acceptance.
// A load first reads the symbol's old count from the symbol table, then
// shifts the whole cell chain at once, so in_ready is low in the cycle after
// a load. While a result waits on out_ready, in_ready stays low for every
// command, so no item is taken until the output register is freed.
// Reset empties the store and readout at once; no clearing pass is needed.
module frequency_sorted_symbol_readout #(
	parameter int SYMBOLS     = 256,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 command,
	input  logic                       first,
	input  logic [fsr_pkg::SYM_W-1:0]  symbol,
	input  logic [fsr_pkg::FREQ_W-1:0] frequency,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [fsr_pkg::SYM_W-1:0]  out_symbol,
	output logic [fsr_pkg::FREQ_W-1:0] out_frequency,
	output logic                       done_res
);

	localparam int SW    = fsr_pkg::SYM_W;
	localparam int FW    = COUNT_WIDTH;
	localparam int KW    = FW + SW;
	localparam int NCELL = (SYMBOLS < fsr_pkg::SYM_RANGE) ? SYMBOLS : fsr_pkg::SYM_RANGE;
	localparam int IW    = $clog2(NCELL);

	logic                accept;
	logic                is_load;
	logic                is_fetch;
	logic                is_rewind;
	logic [31:0]         fq32;
	logic [31:0]         lim32;
	logic [31:0]         sat32;
	logic                sym_ok;

	logic                load_s1;
	logic [SW-1:0]       sym_s1;
	logic [FW-1:0]       freq_s1;
	logic                inr_s1;

	logic                present;
	logic [FW-1:0]       old_freq;

	fsr_pkg::cell_ctrl_t ctrl;
	logic [KW-1:0]       new_key;
	logic [KW-1:0]       old_key;

	logic [NCELL-1:0]    v;
	logic [NCELL-1:0]    cv;
	logic [NCELL-1:0]    b;
	logic [NCELL-1:0]    rv;
	logic [KW-1:0]       k  [NCELL];
	logic [KW-1:0]       ck [NCELL];
	logic [KW-1:0]       rk [NCELL];

	logic                out_valid_q;
	logic [SW-1:0]       out_symbol_q;
	logic [fsr_pkg::FREQ_W-1:0] out_frequency_q;
	logic                done_q;
	logic [31:0]         head_f32;

	// Decode the accepted item
	assign in_ready  = !load_s1 && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign is_load   = accept && (command == fsr_pkg::CMD_LOAD);
	assign is_fetch  = accept && (command == fsr_pkg::CMD_FETCH);
	assign is_rewind = accept && (command == fsr_pkg::CMD_REWIND);

	// Saturate the count to the stored width and check the symbol range
	always_comb begin
		fq32   = {16'd0, frequency};
		lim32  = 32'hFFFF_FFFF >> (32 - FW);
		sat32  = (fq32 > lim32) ? lim32 : fq32;
		sym_ok = ({24'd0, symbol} < 32'(SYMBOLS));
	end

	// Hold the load for its chain update cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_s1 <= 1'b0;
		end else begin
			load_s1 <= is_load;
		end
	end

	always_ff @(posedge clk) begin
		if (is_load) begin
			sym_s1  <= symbol;
			freq_s1 <= sat32[FW-1:0];
			inr_s1  <= sym_ok;
		end
	end

	fsr_side #(
		.NS (NCELL),
		.FW (FW)
	) u_side (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (is_load),
		.clr      (is_load && first),
		.rd_idx   (symbol[IW-1:0]),
		.wr_en    (load_s1 && inr_s1),
		.wr_idx   (sym_s1[IW-1:0]),
		.wr_freq  (freq_s1),
		.present  (present),
		.old_freq (old_freq)
	);

	// Broadcast control and keys to the chain
	always_comb begin
		ctrl.clr = is_load && first;
		ctrl.upd = load_s1 && inr_s1;
		ctrl.rem = load_s1 && inr_s1 && present;
		ctrl.ins = load_s1 && inr_s1 && (freq_s1 != '0);
		ctrl.rew = is_rewind || (load_s1 && !inr_s1);
		ctrl.adv = is_fetch;
		new_key  = {freq_s1, sym_s1};
		old_key  = {old_freq, sym_s1};
	end

	// Row of cells, each wired to its neighbours
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic          p_cv;
		logic [KW-1:0] p_ck;
		logic          p_b;
		logic          n_v;
		logic [KW-1:0] n_k;
		logic          n_rv;
		logic [KW-1:0] n_rk;

		if (i == 0) begin : g_head
			assign p_cv = 1'b0;
			assign p_ck = '0;
			assign p_b  = 1'b0;
		end else begin : g_mid
			assign p_cv = cv[i-1];
			assign p_ck = ck[i-1];
			assign p_b  = b[i-1];
		end

		if (i == NCELL - 1) begin : g_tail
			assign n_v  = 1'b0;
			assign n_k  = '0;
			assign n_rv = 1'b0;
			assign n_rk = '0;
		end else begin : g_body
			assign n_v  = v[i+1];
			assign n_k  = k[i+1];
			assign n_rv = rv[i+1];
			assign n_rk = rk[i+1];
		end

		fsr_cell #(
			.KW (KW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.new_key (new_key),
			.old_key (old_key),
			.prev_cv (p_cv),
			.prev_ck (p_ck),
			.prev_b  (p_b),
			.next_v  (n_v),
			.next_k  (n_k),
			.next_rv (n_rv),
			.next_rk (n_rk),
			.v       (v[i]),
			.k       (k[i]),
			.cv      (cv[i]),
			.ck      (ck[i]),
			.b       (b[i]),
			.rv      (rv[i]),
			.rk      (rk[i])
		);
	end

	// Take the readout head into the output register on fetch
	assign head_f32 = 32'(rk[0][KW-1:SW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (is_fetch) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_fetch) begin
			out_symbol_q    <= rv[0] ? rk[0][SW-1:0] : '0;
			out_frequency_q <= rv[0] ? head_f32[fsr_pkg::FREQ_W-1:0] : '0;
			done_q          <= !rv[0];
		end
	end

	assign out_valid     = out_valid_q;
	assign out_symbol    = out_symbol_q;
	assign out_frequency = out_frequency_q;
	assign done_res      = done_q;

	// A load owns the cycle after it
	a_load_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 |-> !in_ready)
		else $error("item accepted during load update");

	// Stored entries stay packed at the head of the chain
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((v + 1'b1) & v) == '0)
		else $error("gap in stored entries");

	// The readout is never nonempty while the store is empty
	a_readout_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		rv[0] |-> v[0])
		else $error("readout entry with empty store");

	// A done result carries zero fields
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> (out_symbol == '0 && out_frequency == '0))
		else $error("done result with nonzero fields");

	// The head of the store holds a larger key than the entry behind it
	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(v[0] && v[1]) |-> (k[0] > k[1]))
		else $error("store head out of order");

endmodule

@@ bench/frequency_sorted_symbol_readout_test.sv @@
`timescale 1ns / 1ps

module frequency_sorted_symbol_readout_test;

	// Command three has no meaning and must be ignored
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int SW = fsr_pkg::SYM_W;
	localparam int FW = fsr_pkg::FREQ_W;
	localparam int NSYM = fsr_pkg::SYM_RANGE;
	localparam int RANDOM_ITEMS = 650;
	localparam int STALL_LIMIT = 1000;
	localparam int SQUEEZE_CYCLES = 200;
	localparam int SETTLE_CYCLES = 10;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [SW-1:0] sym;
		logic [FW-1:0] freq;
		logic          done;
	} readout_t;

	typedef struct packed {
		logic [1:0]    cmd;
		logic          first;
		logic [SW-1:0] sym;
		logic [FW-1:0] freq;
		logic          typed;
		readout_t      want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [1:0]          command = fsr_pkg::CMD_LOAD;
	logic                first = 1'b0;
	logic [SW-1:0]       symbol = '0;
	logic [FW-1:0]       frequency = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [SW-1:0]       out_symbol;
	logic [FW-1:0]       out_frequency;
	logic                done_res;

	// Sorted store held by the predictor, highest key first
	logic [SW-1:0]       store_sym [NSYM];
	logic [FW-1:0]       store_freq [NSYM];
	int                  store_count = 0;
	int                  read_pos = 0;

	readout_t            pending_readouts [$];
	stim_row_t           directed_rows [$];
	int                  mismatches = 0;
	int                  items_sent = 0;
	int                  stall_cycles = 0;
	logic                calm = 1'b0;
	logic                squeeze = 1'b0;
	logic                hold_rx = 1'b0;

	frequency_sorted_symbol_readout u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.first        (first),
		.symbol       (symbol),
		.frequency    (frequency),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_symbol   (out_symbol),
		.out_frequency(out_frequency),
		.done_res     (done_res)
	);

	always #5 clk = ~clk;

	// Advance the sorted store by one item and work out any readout it causes
	function automatic void predict_readout(input logic [1:0] cmd, input logic first_f,
			input logic [SW-1:0] sym, input logic [FW-1:0] freq,
			output logic has_res, output readout_t res);
		int i;
		int hit;
		int pos;
		has_res = 1'b0;
		res = '0;
		case (cmd)
			fsr_pkg::CMD_LOAD: begin
				if (first_f)
					store_count = 0;
				read_pos = 0;
				// take out an older count of the same symbol
				hit = -1;
				for (i = 0; i < store_count; i++)
					if (hit < 0 && store_sym[i] == sym)
						hit = i;
				if (hit >= 0) begin
					for (i = hit; i < store_count - 1; i++) begin
						store_sym[i] = store_sym[i + 1];
						store_freq[i] = store_freq[i + 1];
					end
					store_count--;
				end
				// place a nonzero count below every larger key
				if (freq != '0 && store_count < NSYM) begin
					pos = 0;
					while (pos < store_count && {store_freq[pos], store_sym[pos]} > {freq, sym})
						pos++;
					for (i = store_count; i > pos; i--) begin
						store_sym[i] = store_sym[i - 1];
						store_freq[i] = store_freq[i - 1];
					end
					store_sym[pos] = sym;
					store_freq[pos] = freq;
					store_count++;
				end
			end
			fsr_pkg::CMD_FETCH: begin
				has_res = 1'b1;
				if (read_pos < store_count) begin
					res.sym = store_sym[read_pos];
					res.freq = store_freq[read_pos];
					read_pos++;
				end else begin
					res.done = 1'b1;
				end
			end
			fsr_pkg::CMD_REWIND: begin
				read_pos = 0;
			end
			default: ;
		endcase
	endfunction

	// Offer one item, hold it until taken, then record what it should produce
	task automatic offer_item(input logic [1:0] cmd, input logic first_f,
			input logic [SW-1:0] sym, input logic [FW-1:0] freq,
			input logic typed, input readout_t want);
		int gap;
		logic has_res;
		readout_t res;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < 37)
				gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		first <= first_f;
		symbol <= sym;
		frequency <= freq;
		do @(posedge clk); while (!in_ready);
		predict_readout(cmd, first_f, sym, freq, has_res, res);
		if (has_res)
			pending_readouts.push_back(typed ? want : res);
		if (cmd != CMD_SPARE)
			items_sent++;
	endtask

	function automatic void add_row(input logic [1:0] cmd, input logic first_f,
			input logic [SW-1:0] sym, input logic [FW-1:0] freq, input logic typed,
			input logic [SW-1:0] w_sym, input logic [FW-1:0] w_freq,
			input logic w_done);
		stim_row_t row;
		row.cmd = cmd;
		row.first = first_f;
		row.sym = sym;
		row.freq = freq;
		row.typed = typed;
		row.want.sym = w_sym;
		row.want.freq = w_freq;
		row.want.done = w_done;
		directed_rows.push_back(row);
	endfunction

	// Random count: zero, the largest, a narrow range for ties, or anything
	function automatic logic [FW-1:0] pick_freq();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 15)
			return '1;
		if (r < 55)
			return FW'($urandom_range(4, 1));
		return FW'($urandom);
	endfunction

	// Receive results and compare them with the oldest expectation
	always @(posedge clk) begin : rx_check
		readout_t want;
		if (hold_rx)
			out_ready <= 1'b0;
		else
			out_ready <= calm || ($urandom_range(99) >= 37);
		if (arst_n && out_valid && out_ready) begin
			if (pending_readouts.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected readout: symbol %0d frequency %0d done %0b",
						out_symbol, out_frequency, done_res);
			end else begin
				want = pending_readouts.pop_front();
				if (out_symbol !== want.sym || out_frequency !== want.freq ||
						done_res !== want.done) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"readout mismatch: symbol %0d/%0d frequency %0d/%0d",
							" done %0b/%0b (exp/act)"},
							want.sym, out_symbol, want.freq, out_frequency,
							want.done, done_res);
				end
			end
		end
	end

	// Hold off the receiver for a long stretch so the block stalls its input
	initial begin
		wait (squeeze);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (SQUEEZE_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// End the run when nothing has moved for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		int n;
		int k;
		int nf;
		int target;
		int order [NSYM];
		int tmp;
		logic full_done;
		logic [SW-1:0] sym;
		logic [SW-1:0] set_syms [$];

		full_done = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty store, extremes, ties, reload, removal, clear, spare command
		add_row(fsr_pkg::CMD_FETCH, 1'b0, 8'h00, 16'h0000, 1'b1, 8'h00, 16'h0000, 1'b1);
		add_row(fsr_pkg::CMD_REWIND, 1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(fsr_pkg::CMD_LOAD, 1'b1, 8'h10, 16'd100, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(fsr_pkg::CMD_LOAD, 1'b0, 8'hFF, 16'hFFFF, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(fsr_pkg::CMD_LOAD, 1'b0, 8'h00, 16'h0001, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(fsr_pkg::CMD_LOAD, 1'b0, 8'h20, 16'd100, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(fsr_pkg::CMD_FETCH, 1'b0, 8'h00, 16'h0000, 1'b1, 8'hFF, 16'hFFFF, 1'b0);
		add_row(fsr_pkg::CMD_FETCH, 1'b0, 8'h00, 16'h0000, 1'b1, 8'h20, 16'd100, 1'b0);
		add_row(fsr_pkg::CMD_REWIND, 1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(fsr_pkg::CMD_FETCH, 1'b0, 8'h00, 16'h0000, 1'b1, 8'hFF, 16'hFFFF, 1'b0);
		add_row(fsr_pkg::CMD_LOAD, 1'b0, 8'h10, 16'd5, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(fsr_pkg::CMD_FETCH, 1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(fsr_pkg::CMD_FETCH, 1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(fsr_pkg::CMD_FETCH, 1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(fsr_pkg::CMD_FETCH, 1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(fsr_pkg::CMD_FETCH, 1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(fsr_pkg::CMD_LOAD, 1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(CMD_SPARE, 1'b1, 8'hFF, 16'hFFFF, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(fsr_pkg::CMD_FETCH, 1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(fsr_pkg::CMD_LOAD, 1'b1, 8'h80, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(fsr_pkg::CMD_FETCH, 1'b0, 8'h00, 16'h0000, 1'b1, 8'h00, 16'h0000, 1'b1);
		add_row(fsr_pkg::CMD_LOAD, 1'b1, 8'h55, 16'hAAAA, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(fsr_pkg::CMD_FETCH, 1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0);
		add_row(fsr_pkg::CMD_FETCH, 1'b0, 8'h00, 16'h0000, 1'b0, 8'h00, 16'h0000, 1'b0);
		foreach (directed_rows[i])
			offer_item(directed_rows[i].cmd, directed_rows[i].first, directed_rows[i].sym,
				directed_rows[i].freq, directed_rows[i].typed, directed_rows[i].want);

		// Random part: mostly whole sets read back, some noise
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			if (!full_done && items_sent > 300) begin
				// fill every symbol in shuffled order, without idling
				full_done = 1'b1;
				for (k = 0; k < NSYM; k++)
					order[k] = k;
				for (k = NSYM - 1; k > 0; k--) begin
					n = $urandom_range(k, 0);
					tmp = order[k];
					order[k] = order[n];
					order[n] = tmp;
				end
				calm <= 1'b1;
				for (k = 0; k < NSYM; k++)
					offer_item(fsr_pkg::CMD_LOAD, k == 0, SW'(order[k]),
						FW'($urandom_range(8, 1)), 1'b0, '0);
				calm <= 1'b0;
				// read back under a long receiver hold-off
				squeeze <= 1'b1;
				for (k = 0; k < 40; k++)
					offer_item(fsr_pkg::CMD_FETCH, 1'($urandom_range(1)), SW'($urandom),
						FW'($urandom), 1'b0, '0);
				offer_item(fsr_pkg::CMD_REWIND, 1'b0, '0, '0, 1'b0, '0);
				for (k = 0; k < 10; k++)
					offer_item(fsr_pkg::CMD_FETCH, 1'b0, '0, '0, 1'b0, '0);
			end else if ($urandom_range(99) < 80) begin
				// well-formed set: loads, then fetches up to and sometimes past the end, with occasional rewinds
				n = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
				set_syms.delete();
				for (k = 0; k < n; k++) begin
					if (set_syms.size() > 0 && $urandom_range(99) < 30)
						sym = set_syms[$urandom_range(set_syms.size() - 1)];
					else
						sym = SW'($urandom);
					set_syms.push_back(sym);
					offer_item(fsr_pkg::CMD_LOAD, k == 0 && $urandom_range(9) != 0, sym,
						pick_freq(), 1'b0, '0);
				end
				nf = store_count + $urandom_range(3);
				for (k = 0; k < nf; k++) begin
					if ($urandom_range(99) < 6)
						offer_item(fsr_pkg::CMD_REWIND, 1'($urandom_range(1)),
							SW'($urandom), FW'($urandom), 1'b0, '0);
					offer_item(fsr_pkg::CMD_FETCH, 1'($urandom_range(1)), SW'($urandom),
						FW'($urandom), 1'b0, '0);
				end
			end else begin
				// noise: any command, any fields
				n = $urandom_range(6, 1);
				for (k = 0; k < n; k++)
					offer_item(2'($urandom_range(3)), 1'($urandom_range(1)), SW'($urandom),
						pick_freq(), 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		// Drain outstanding readouts, then allow the block to settle
		while (pending_readouts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_readouts.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/fsr_pkg.sv
hw/rtl/fsr_cell.sv
hw/rtl/fsr_side.sv
hw/rtl/frequency_sorted_symbol_readout.sv
bench/frequency_sorted_symbol_readout_test.sv
